/* design/ngflt_pkg.sv */
// Shared constants, codes and control types for the n-gram frequency table.
// No dependencies; every other file in the design but ngflt_ram imports this package.
`timescale 1ns / 1ps

package ngflt_pkg;

  localparam int TABLE_DEPTH     = 256;
  localparam int MAX_KEY_CHARS   = 4;
  localparam int KEY_FIELD_BYTES = 4;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int OP_W    = 2;
  localparam int LEN_W   = 3;
  localparam int CHARS_W = 32;
  localparam int KEY_W   = LEN_W + CHARS_W;
  localparam int FREQ_W  = 16;
  localparam int ENTRY_W = KEY_W + FREQ_W;
  localparam int TOTAL_W = 32;
  localparam int NORM_W  = 26;
  localparam int STAT_W  = 2;

  localparam int TOTAL_DIVISOR = 100;
  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for every 32-bit x
  localparam logic [TOTAL_W-1:0] DIV100_MUL   = 32'h51EB_851F;
  localparam int                 DIV100_SHIFT = 37;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 48;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_LEN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT_WR,
    ST_DIVIDE,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic rd_mid;
    logic search_step;
    logic decide;
    logic rd_shift;
    logic wr_shift;
    logic wr_insert;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic             op_lookup;
    logic             op_insert;
    logic             op_clear;
    logic             len_ok;
    logic             lo_lt_hi;
    logic             match;
    logic             table_full;
    logic             shift_more;
    logic             out_free;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
  } dp_status_t;

endpackage

/* design/ngflt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ngflt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ngflt_ctrl.sv */
// Sequencer for the n-gram table: search, shift, insert, total division, result.
// Depends on ngflt_pkg; drives ngflt_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module ngflt_ctrl
  import ngflt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if ((status.op_lookup || status.op_insert) && status.len_ok) begin
          state_next = ST_SEARCH_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SEARCH_RD: begin
        state_next = status.lo_lt_hi ? ST_SEARCH_CMP : ST_DECIDE;
      end
      ST_SEARCH_CMP: state_next = ST_SEARCH_RD;
      ST_DECIDE: begin
        if (status.op_lookup) begin
          state_next = ST_DONE;
        end else if (status.match) begin
          state_next = ST_INSERT_WR;
        end else if (status.table_full) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: begin
        state_next = status.shift_more ? ST_SHIFT_WR : ST_INSERT_WR;
      end
      ST_SHIFT_WR:  state_next = ST_SHIFT_RD;
      ST_INSERT_WR: state_next = ST_DIVIDE;
      ST_DIVIDE:    state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_DISPATCH:   cmd.clear       = status.op_clear;
      ST_SEARCH_RD:  cmd.rd_mid      = status.lo_lt_hi;
      ST_SEARCH_CMP: cmd.search_step = 1'b1;
      ST_DECIDE:     cmd.decide      = 1'b1;
      ST_SHIFT_RD:   cmd.rd_shift    = status.shift_more;
      ST_SHIFT_WR:   cmd.wr_shift    = 1'b1;
      ST_INSERT_WR:  cmd.wr_insert   = 1'b1;
      ST_DIVIDE:     cmd.div_step    = 1'b1;
      ST_DONE:       cmd.load_out    = status.out_free;
      default: begin
        cmd      = '0;
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

/* design/ngflt_datapath.sv */
// Datapath for the n-gram table: item registers, search bounds, table RAM,
// saturating total with divide by 100 by reciprocal multiply, output register.
// Depends on ngflt_pkg and ngflt_ram.
`timescale 1ns / 1ps

module ngflt_datapath
  import ngflt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [OP_W-1:0]      s_tuser,
  input  logic                 default_frequency_we,
  input  logic [FREQ_W-1:0]    default_frequency_wdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  // item registers
  logic [OP_W-1:0]    op;
  logic [CHARS_W-1:0] chars;
  logic [LEN_W-1:0]   len;
  logic [FREQ_W-1:0]  efreq;

  logic [FREQ_W-1:0]  default_frequency;
  logic [CNT_W-1:0]   entry_count;
  logic [TOTAL_W-1:0] total;
  logic [NORM_W-1:0]  norm_total;

  logic [CNT_W-1:0]   lo, hi, j;
  logic               match;
  logic [FREQ_W-1:0]  match_freq;
  logic               full_hit;

  logic               len_ok;
  logic [CHARS_W-1:0] chars_masked;
  logic [KEY_W-1:0]   key;
  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   j_prev;
  logic [KEY_W-1:0]   rkey;

  logic [TOTAL_W:0]     sum;
  logic [TOTAL_W-1:0]   total_next;
  logic [2*TOTAL_W-1:0] norm_prod;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic               res_found;
  logic [FREQ_W-1:0]  res_freq;
  logic [STAT_W-1:0]  res_status;

  assign len_ok = (len >= LEN_W'(1)) && (len <= LEN_W'(MAX_KEY_CHARS))
               && (len <= LEN_W'(KEY_FIELD_BYTES));

  // bytes past the key length read as zero
  always_comb begin
    chars_masked = '0;
    for (int b = 0; b < KEY_FIELD_BYTES; b++) begin
      if (LEN_W'(b) < len) begin
        chars_masked[CHARS_W-1-8*b -: 8] = chars[CHARS_W-1-8*b -: 8];
      end
    end
  end

  assign key     = {len, chars_masked};
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign j_prev  = j - CNT_W'(1);
  assign rkey    = ram_rdata[ENTRY_W-1:FREQ_W];

  assign sum        = {1'b0, total} + (TOTAL_W + 1)'(efreq);
  assign total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  // divide by 100: multiply by the scaled reciprocal, keep the high bits
  assign norm_prod = {{TOTAL_W{1'b0}}, total} * {{TOTAL_W{1'b0}}, DIV100_MUL};

  always_comb begin
    ram_we    = cmd.wr_shift || cmd.wr_insert;
    ram_waddr = cmd.wr_shift ? j[ADDR_W-1:0] : lo[ADDR_W-1:0];
    ram_wdata = cmd.wr_shift ? ram_rdata : {key, efreq};
    ram_raddr = cmd.rd_shift ? j_prev[ADDR_W-1:0] : mid[ADDR_W-1:0];
  end

  ngflt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      default_frequency <= '0;
      entry_count       <= '0;
      total             <= '0;
      norm_total        <= '0;
      lo                <= '0;
      hi                <= '0;
      match             <= 1'b0;
      full_hit          <= 1'b0;
    end else begin
      if (default_frequency_we) begin
        default_frequency <= default_frequency_wdata;
      end
      if (cmd.accept) begin
        lo       <= '0;
        hi       <= entry_count;
        match    <= 1'b0;
        full_hit <= 1'b0;
      end
      if (cmd.clear) begin
        entry_count <= '0;
        total       <= '0;
        norm_total  <= '0;
      end
      if (cmd.search_step) begin
        if (rkey < key) begin
          lo <= mid + CNT_W'(1);
        end else begin
          hi <= mid;
        end
        if (rkey == key) begin
          match <= 1'b1;
        end
      end
      if (cmd.decide) begin
        full_hit <= (op == OP_INSERT) && !match && status.table_full;
      end
      if (cmd.wr_insert) begin
        if (!match) entry_count <= entry_count + CNT_W'(1);
        total <= total_next;
      end
      if (cmd.div_step) begin
        norm_total <= norm_prod[DIV100_SHIFT +: NORM_W];
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op    <= s_tuser;
      chars <= s_tdata[CHARS_W-1:0];
      len   <= s_tdata[CHARS_W +: LEN_W];
      efreq <= s_tdata[CHARS_W+LEN_W +: FREQ_W];
    end
    if (cmd.search_step && rkey == key) begin
      match_freq <= ram_rdata[FREQ_W-1:0];
    end
    if (cmd.decide) begin
      j <= entry_count;
    end
    if (cmd.wr_shift) begin
      j <= j_prev;
    end
  end

  always_comb begin
    res_found  = match;
    res_freq   = '0;
    res_status = STATUS_OK;
    case (op)
      OP_LOOKUP: begin
        res_freq = match ? match_freq : default_frequency;
        if (!len_ok) res_status = STATUS_BAD_LEN;
      end
      OP_INSERT: begin
        if (!len_ok) begin
          res_status = STATUS_BAD_LEN;
        end else if (full_hit) begin
          res_status = STATUS_FULL;
        end else begin
          res_freq = efreq;
        end
      end
      default: begin
        res_freq   = '0;
        res_status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {(M_TDATA_W - 1 - FREQ_W - NORM_W - STAT_W)'(0),
                  res_status, norm_total, res_freq, res_found};
    end
  end

  always_comb begin
    status            = '0;
    status.op_lookup  = op == OP_LOOKUP;
    status.op_insert  = op == OP_INSERT;
    status.op_clear   = op == OP_CLEAR;
    status.len_ok     = len_ok;
    status.lo_lt_hi   = lo < hi;
    status.match      = match;
    status.table_full = entry_count >= CNT_W'(TABLE_DEPTH);
    status.shift_more = j > lo;
    status.out_free   = !m_tvalid || m_tready;
    status.lo         = lo;
    status.hi         = hi;
  end

endmodule

/* design/ngram_frequency_lookup_table_top.sv */
// N-gram frequency table, top level: sequencer plus datapath.
// Depends on ngflt_pkg, ngflt_ctrl, ngflt_datapath (and ngflt_ram below it).
//
// Input stream (s_*): one item per command. s_tuser carries the command
// (insert, look up, clear). The table holds keys sorted by length, then by
// characters, and is searched by halving.
// Output stream (m_*): exactly one result item per input item, in order.
// default_frequency_we/_wdata writes the miss value; write only while idle.
//
// Timing: one item in flight. A lookup or insert of valid length makes s halving
// steps (s <= ceil(log2(n+1)) for n entries), each a read state and a compare
// state as the table RAM read is registered, then a decide state. A lookup or a
// full-table refusal then goes to the result; an insert moves m entries up by a
// read and a write state each (none on overwrite), writes, divides the total.
// Clear, unused command and bad length go straight to the result, then idle.
// s_tready is high only between items; a finished result sits in the output
// register, so the next item is taken while the receiver stalls, and its
// result waits until that register is free.
// Reset empties the table, zeroes the total and the miss value; the table RAM
// itself is not cleared, as entries past the fill count are never read.
`timescale 1ns / 1ps

module ngram_frequency_lookup_table_top
  import ngflt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // key_chars [31:0], key_length [34:32], entry_frequency [50:35]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // command [1:0]
  input  logic [OP_W-1:0]      s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // found [0], frequency [16:1], norm_total [42:17], status [44:43]
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 default_frequency_we,
  input  logic [FREQ_W-1:0]    default_frequency_wdata
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  ngflt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (dp_status),
    .cmd     (dp_cmd)
  );

  ngflt_datapath u_datapath (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (dp_cmd),
    .status                 (dp_status),
    .s_tdata                (s_tdata),
    .s_tuser                (s_tuser),
    .default_frequency_we   (default_frequency_we),
    .default_frequency_wdata(default_frequency_wdata),
    .m_tvalid               (m_tvalid),
    .m_tready               (m_tready),
    .m_tdata                (m_tdata)
  );

  // one item at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while one is in progress");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.load_out |=> m_tvalid)
    else $error("loaded result not presented");

  // search window never inverts
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    dp_status.lo <= dp_status.hi)
    else $error("search bounds crossed");

endmodule

/* bench/tb_ngram_frequency_lookup_table_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the n-gram frequency table: directed rows, random traffic,
// full-table and large-total runs, checked by an in-bench model or fixed results.
// Depends on ngflt_pkg and the design sources under design/.

module tb_ngram_frequency_lookup_table_top;
  import ngflt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int TOTAL_INSERTS = 200;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   len;
    logic [FREQ_W-1:0]  efreq;
  } ngram_cmd_t;

  typedef struct packed {
    logic              found;
    logic [FREQ_W-1:0] freq;
    logic [NORM_W-1:0] norm;
    logic [STAT_W-1:0] status;
  } lookup_result_t;

  typedef struct {
    ngram_cmd_t     cmd;
    bit             typed;
    lookup_result_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0]      s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 default_frequency_we = 1'b0;
  logic [FREQ_W-1:0]    default_frequency_wdata = '0;

  // model of the table
  logic [KEY_W-1:0]   tbl_key [TABLE_DEPTH];
  logic [FREQ_W-1:0]  tbl_freq [TABLE_DEPTH];
  int unsigned        n_entries = 0;
  logic [TOTAL_W-1:0] freq_total = '0;
  logic [FREQ_W-1:0]  miss_freq = '0;

  lookup_result_t pending_results [$];
  dir_row_t       dir_rows [$];
  logic [CHARS_W-1:0] fill_keys [$];

  int tx_idle_pct = 17;
  int rx_idle_pct = 45;
  bit tx_on = 1'b0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_full = 0;
  int n_cfg = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ngram_frequency_lookup_table_top dut (
    .clk                     (clk),
    .rst                     (rst),
    .s_tvalid                (s_tvalid),
    .s_tready                (s_tready),
    .s_tdata                 (s_tdata),
    .s_tuser                 (s_tuser),
    .m_tvalid                (m_tvalid),
    .m_tready                (m_tready),
    .m_tdata                 (m_tdata),
    .default_frequency_we    (default_frequency_we),
    .default_frequency_wdata (default_frequency_wdata)
  );

  function automatic logic [CHARS_W-1:0] char_mask(input logic [LEN_W-1:0] len);
    if (len >= 1 && len <= 4) return 32'hFFFF_FFFF << (CHARS_W - 8 * len);
    return '0;
  endfunction

  function automatic bit len_valid(input logic [LEN_W-1:0] len);
    return len >= 1 && len <= MAX_KEY_CHARS && len <= KEY_FIELD_BYTES;
  endfunction

  // Works out the result of one item and updates the model table.
  function automatic lookup_result_t table_predict(input ngram_cmd_t c);
    logic [KEY_W-1:0]   k;
    logic [TOTAL_W:0]   sum;
    int unsigned        lo;
    int unsigned        hi;
    int unsigned        mid;
    bit                 hit;
    lookup_result_t     r;
    r = '0;
    k = {c.len, c.chars & char_mask(c.len)};
    lo = 0;
    hi = n_entries;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_key[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < n_entries) && (tbl_key[lo] == k);
    case (c.op)
      OP_INSERT: begin
        if (!len_valid(c.len)) begin
          r.status = STATUS_BAD_LEN;
        end else if (!hit && n_entries >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          if (!hit) begin
            for (int i = n_entries; i > lo; i--) begin
              tbl_key[i]  = tbl_key[i-1];
              tbl_freq[i] = tbl_freq[i-1];
            end
            tbl_key[lo] = k;
            n_entries++;
          end
          tbl_freq[lo] = c.efreq;
          r.found = hit;
          r.freq = c.efreq;
          sum = freq_total + c.efreq;
          freq_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        end
      end
      OP_LOOKUP: begin
        r.freq = miss_freq;
        if (!len_valid(c.len)) begin
          r.status = STATUS_BAD_LEN;
        end else if (hit) begin
          r.found = 1'b1;
          r.freq = tbl_freq[lo];
        end
      end
      OP_CLEAR: begin
        n_entries = 0;
        freq_total = '0;
      end
      default: ;
    endcase
    r.norm = NORM_W'(freq_total / TOTAL_DIVISOR);
    return r;
  endfunction

  function automatic ngram_cmd_t rand_item(input bit allow_clear);
    ngram_cmd_t c;
    int         r;
    logic [7:0] b;
    c = '0;
    r = $urandom_range(99);
    if (r < 45) c.op = OP_INSERT;
    else if (r < 92) c.op = OP_LOOKUP;
    else if (r < 96) c.op = allow_clear ? OP_CLEAR : OP_LOOKUP;
    else c.op = OP_UNUSED;
    if ($urandom_range(9) != 0) c.len = LEN_W'($urandom_range(1, MAX_KEY_CHARS));
    else c.len = LEN_W'($urandom_range(7));
    if ($urandom_range(6) == 0) begin
      c.chars = $urandom;
    end else begin
      // small alphabet so that keys repeat and lookups hit
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(3))
          0: b = 8'h00;
          1: b = 8'h41;
          2: b = 8'h7A;
          default: b = 8'hFF;
        endcase
        c.chars = {c.chars[23:0], b};
      end
      if ($urandom_range(2) == 0) c.chars |= $urandom & ~char_mask(c.len);
    end
    case ($urandom_range(9))
      0: c.efreq = '0;
      1: c.efreq = '1;
      default: c.efreq = FREQ_W'($urandom_range(16'hFFFF));
    endcase
    return c;
  endfunction

  function automatic ngram_cmd_t mk_cmd(input logic [OP_W-1:0] op, input logic [CHARS_W-1:0] chars,
                                        input logic [LEN_W-1:0] len, input logic [FREQ_W-1:0] efreq);
    ngram_cmd_t c;
    c.op = op;
    c.chars = chars;
    c.len = len;
    c.efreq = efreq;
    return c;
  endfunction

  task automatic add_row(input ngram_cmd_t c, input bit typed, input logic found,
                         input logic [FREQ_W-1:0] freq, input logic [NORM_W-1:0] norm,
                         input logic [STAT_W-1:0] status);
    dir_row_t row;
    row.cmd = c;
    row.typed = typed;
    row.want = {found, freq, norm, status};
    dir_rows.push_back(row);
  endtask

  task automatic send_item(input ngram_cmd_t c, input bit typed, input lookup_result_t want);
    lookup_result_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      if (tx_on) begin
        s_tvalid <= 1'b0;
        tx_on = 1'b0;
      end
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    tx_on = 1'b1;
    s_tdata <= S_TDATA_W'({c.efreq, c.len, c.chars});
    s_tuser <= c.op;
    do @(posedge clk); while (!s_tready);
    got = table_predict(c);
    if (c.op == OP_LOOKUP && got.found) n_hits++;
    if (got.status == STATUS_FULL) n_full++;
    pending_results.push_back(typed ? want : got);
    n_sent++;
  endtask

  task automatic send(input ngram_cmd_t c);
    send_item(c, 1'b0, '0);
  endtask

  task automatic run_random(input int count, input bit allow_clear);
    repeat (count) send(rand_item(allow_clear));
  endtask

  task automatic wait_drain();
    if (tx_on) begin
      s_tvalid <= 1'b0;
      tx_on = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_miss_freq(input logic [FREQ_W-1:0] v);
    wait_drain();
    default_frequency_we <= 1'b1;
    default_frequency_wdata <= v;
    @(posedge clk);
    default_frequency_we <= 1'b0;
    miss_freq = v;
    n_cfg++;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      m_tready <= 1'b0;
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    lookup_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing outstanding: m_tdata=%h", m_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", want.found, m_tdata[0]);
        check_field("frequency", want.freq, m_tdata[16:1]);
        check_field("norm_total", want.norm, m_tdata[42:17]);
        check_field("status", want.status, m_tdata[44:43]);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CHARS_W-1:0] k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed rows; miss value is 0 after reset
    add_row(mk_cmd(OP_LOOKUP, 32'h4100_0000, 1, 0), 1, 0, 0, 0, STATUS_OK);
    add_row(mk_cmd(OP_INSERT, 32'h4100_0000, 0, 5), 1, 0, 0, 0, STATUS_BAD_LEN);
    add_row(mk_cmd(OP_INSERT, 32'hFFFF_FFFF, 7, 9), 1, 0, 0, 0, STATUS_BAD_LEN);
    add_row(mk_cmd(OP_LOOKUP, 32'h4100_0000, 0, 0), 1, 0, 0, 0, STATUS_BAD_LEN);
    add_row(mk_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 5, 0), 1, 0, 0, 0, STATUS_BAD_LEN);
    add_row(mk_cmd(OP_INSERT, 32'hFFFF_FFFF, 4, 16'hFFFF), 1, 0, 16'hFFFF, 655, STATUS_OK);
    add_row(mk_cmd(OP_INSERT, 32'h0000_0000, 1, 0), 0, 0, 0, 0, 0);
    // low bytes beyond the key length must be ignored
    add_row(mk_cmd(OP_INSERT, 32'h41FF_FFFF, 1, 1234), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_LOOKUP, 32'h4100_0000, 1, 0), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_LOOKUP, 32'h4112_3456, 1, 0), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_INSERT, 32'h41AB_CDEF, 1, 7), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_INSERT, 32'h4100_ABCD, 2, 100), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_LOOKUP, 32'h4100_0000, 2, 0), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_LOOKUP, 32'h4100_0000, 3, 0), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_INSERT, 32'hFFFF_FFFF, 4, 0), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 4, 0), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_UNUSED, 32'hFFFF_FFFF, 7, 16'hFFFF), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_INSERT, 32'h0000_0000, 3, 16'hFFFF), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_LOOKUP, 32'h0000_0000, 1, 0), 0, 0, 0, 0, 0);
    add_row(mk_cmd(OP_CLEAR, 32'h0000_0000, 0, 0), 1, 0, 0, 0, STATUS_OK);
    add_row(mk_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 4, 0), 1, 0, 0, 0, STATUS_OK);
    add_row(mk_cmd(OP_UNUSED, 32'h0000_0000, 0, 0), 1, 0, 0, 0, STATUS_OK);
    add_row(mk_cmd(OP_INSERT, 32'h7A00_0000, 6, 16'h8000), 1, 0, 0, 0, STATUS_BAD_LEN);
    foreach (dir_rows[i]) send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

    // random traffic: sender idles lightly, receiver heavily, then the other way round
    set_miss_freq(16'hFFFF);
    hold_req <= hold_req + 1;
    run_random(700, 1'b1);

    set_miss_freq(16'h0000);
    tx_idle_pct = 45;
    rx_idle_pct = 17;
    run_random(700, 1'b1);

    // fill the table to capacity in scrambled order, then hammer it
    set_miss_freq(FREQ_W'($urandom_range(1, 16'hFFFE)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send(mk_cmd(OP_CLEAR, $urandom, LEN_W'($urandom), FREQ_W'($urandom)));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      k = {8'(i * 167), 24'($urandom)};
      fill_keys.push_back(k);
      send(mk_cmd(OP_INSERT, k, 4, FREQ_W'($urandom)));
    end
    send(mk_cmd(OP_INSERT, 32'h4100_0000, 1, 16'h1111));
    send(mk_cmd(OP_INSERT, 32'hFFFF_FF00, 3, 16'h2222));
    send(mk_cmd(OP_INSERT, fill_keys[0], 4, 16'hFFFF));
    hold_req <= hold_req + 1;
    for (int i = 0; i < 200; i++) begin
      if ($urandom_range(1) == 0)
        send(mk_cmd($urandom_range(1) ? OP_INSERT : OP_LOOKUP,
                    fill_keys[$urandom_range(TABLE_DEPTH - 1)], 4, FREQ_W'($urandom)));
      else
        send(rand_item(1'b0));
      if (i == 100) wait_drain();
    end

    // push the running total up on a single key
    set_miss_freq(16'h8001);
    send(mk_cmd(OP_CLEAR, 0, 0, 0));
    repeat (TOTAL_INSERTS) send(mk_cmd(OP_INSERT, 32'h7A41_0000, 2, 16'hFFFF));
    send(mk_cmd(OP_INSERT, 32'h7A41_0000, 2, 16'h0001));
    send(mk_cmd(OP_LOOKUP, 32'h7A41_0000, 2, 0));
    send(mk_cmd(OP_LOOKUP, 32'h7A42_0000, 2, 0));

    wait_drain();
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      err_cnt++;
    end
    $display("Sent %0d items, checked %0d results: %0d lookup hits, %0d full-table refusals,",
             n_sent, n_checked, n_hits, n_full);
    $display("%0d miss-value writes, final running total %0d", n_cfg, freq_total);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
design/ngflt_pkg.sv
design/ngflt_ram.sv
design/ngflt_ctrl.sv
design/ngflt_datapath.sv
design/ngram_frequency_lookup_table_top.sv
bench/tb_ngram_frequency_lookup_table_top.sv
